[rtl/ssq_pkg.sv]
// types, constants and codes shared by the sorted priority queue modules
`default_nettype none

package ssq_pkg;

    localparam int CAPACITY_DEF = 16;
    localparam int ELEM_W       = 32;
    localparam int PRIO_W       = 8;
    localparam int ENTRY_W      = ELEM_W + PRIO_W;
    localparam int OCC_W        = 5;

    typedef enum logic {
        OP_INSERT = 1'b0,
        OP_REMOVE = 1'b1
    } t_op;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2
    } t_status;

    typedef enum logic [1:0] {
        S_IDLE,
        S_INS,
        S_PUT,
        S_REM
    } t_state;

    typedef struct packed {
        logic    load_tail;
        logic    load_head;
        logic    shift;
        logic    put_next;
        logic    put_front;
        logic    pop;
        logic    fin;
        t_status fin_status;
    } t_cmd;

    typedef struct packed {
        logic count_zero;
        logic full;
        logic idx_zero;
        logic prio_gt;
    } t_stat;

endpackage

`default_nettype wire

[rtl/ssq_ram.sv]
// generic simple dual-port ram, one write port, one registered read port
`default_nettype none

module ssq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic [AW-1:0]    i_raddr,
    output logic      [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

[rtl/ssq_dp.sv]
// datapath: circular sorted store, head and count registers, result registers
`default_nettype none

module ssq_dp import ssq_pkg::*; #(
    parameter int CAPACITY = CAPACITY_DEF
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  wire logic signed [ELEM_W-1:0] i_element,
    input  wire logic        [PRIO_W-1:0] i_priority_req,
    input  wire t_cmd                     i_cmd,
    output t_stat                         o_stat,
    output logic                          o_strobe,
    output logic signed      [ELEM_W-1:0] o_removed_element,
    output logic             [1:0]        o_status,
    output logic             [OCC_W-1:0]  o_occupancy
);

    localparam int AW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);

    logic [CW-1:0]          r_count, n_count;
    logic [AW-1:0]          r_head, n_head;
    logic [AW-1:0]          r_idx, n_idx;
    logic [ELEM_W-1:0]      r_elem;
    logic [PRIO_W-1:0]      r_prio;
    logic                   r_strobe;
    logic [ELEM_W-1:0]      r_removed;
    t_status                r_status;
    logic [OCC_W-1:0]       r_occ;

    logic                   ram_we;
    logic [AW-1:0]          ram_waddr;
    logic [ENTRY_W-1:0]     ram_wdata;
    logic [AW-1:0]          ram_raddr;
    logic [ENTRY_W-1:0]     ram_rdata;
    logic [CW-1:0]          count_m1;

    function automatic logic [AW-1:0] phys(input logic [AW-1:0] a, input logic [AW-1:0] b);
        logic [AW:0] s;
        s = {1'b0, a} + {1'b0, b};
        if (s >= (AW+1)'(CAPACITY)) begin
            s = s - (AW+1)'(CAPACITY);
        end
        return s[AW-1:0];
    endfunction

    assign count_m1 = r_count - CW'(1);

    always_comb begin
        n_count = r_count;
        n_head  = r_head;
        n_idx   = r_idx;
        if (i_cmd.load_tail) begin
            n_idx = AW'(count_m1);
        end else if (i_cmd.load_head) begin
            n_idx = '0;
        end else if (i_cmd.shift) begin
            n_idx = r_idx - AW'(1);
        end
        if (i_cmd.put_next || i_cmd.put_front) begin
            n_count = r_count + CW'(1);
        end else if (i_cmd.pop) begin
            n_count = count_m1;
            n_head  = phys(r_head, AW'(1));
        end
    end

    always_comb begin
        ram_we    = i_cmd.shift || i_cmd.put_next || i_cmd.put_front;
        ram_waddr = i_cmd.put_front ? r_head : phys(r_head, r_idx + AW'(1));
        ram_wdata = i_cmd.shift ? ram_rdata : {r_prio, r_elem};
        ram_raddr = phys(r_head, n_idx);
    end

    ssq_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (CAPACITY)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count  <= '0;
            r_head   <= '0;
            r_strobe <= 1'b0;
        end else begin
            r_count  <= n_count;
            r_head   <= n_head;
            r_strobe <= i_cmd.fin;
        end
    end

    always_ff @(posedge i_clk) begin
        r_idx <= n_idx;
        if (i_cmd.load_tail || i_cmd.load_head) begin
            r_elem <= i_element;
            r_prio <= i_priority_req;
        end
        if (i_cmd.fin) begin
            r_status  <= i_cmd.fin_status;
            r_removed <= i_cmd.pop ? ram_rdata[ELEM_W-1:0] : '0;
            r_occ     <= OCC_W'(n_count);
        end
    end

    assign o_stat.count_zero = (r_count == '0);
    assign o_stat.full       = (r_count == CW'(CAPACITY));
    assign o_stat.idx_zero   = (r_idx == '0);
    assign o_stat.prio_gt    = (ram_rdata[ENTRY_W-1:ELEM_W] > r_prio);

    assign o_strobe          = r_strobe;
    assign o_removed_element = r_removed;
    assign o_status          = r_status;
    assign o_occupancy       = r_occ;

endmodule

`default_nettype wire

[rtl/ssq_ctrl.sv]
// controller: state machine sequencing insert walk, put and remove
`default_nettype none

module ssq_ctrl import ssq_pkg::*; (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire logic  i_start,
    input  wire logic  i_op,
    input  wire t_stat i_stat,
    output t_cmd       o_cmd,
    output logic       o_busy
);

    t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        o_cmd.fin_status = ST_OK;
        unique case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    if (t_op'(i_op) == OP_INSERT) begin
                        if (i_stat.full) begin
                            o_cmd.fin        = 1'b1;
                            o_cmd.fin_status = ST_FULL;
                        end else begin
                            o_cmd.load_tail = 1'b1;
                            n_state = i_stat.count_zero ? S_PUT : S_INS;
                        end
                    end else begin
                        if (i_stat.count_zero) begin
                            o_cmd.fin        = 1'b1;
                            o_cmd.fin_status = ST_EMPTY;
                        end else begin
                            o_cmd.load_head = 1'b1;
                            n_state = S_REM;
                        end
                    end
                end
            end
            S_INS: begin
                if (i_stat.prio_gt) begin
                    o_cmd.shift = 1'b1;
                    if (i_stat.idx_zero) begin
                        n_state = S_PUT;
                    end
                end else begin
                    o_cmd.put_next = 1'b1;
                    o_cmd.fin      = 1'b1;
                    n_state = S_IDLE;
                end
            end
            S_PUT: begin
                o_cmd.put_front = 1'b1;
                o_cmd.fin       = 1'b1;
                n_state = S_IDLE;
            end
            S_REM: begin
                o_cmd.pop = 1'b1;
                o_cmd.fin = 1'b1;
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_busy = (r_state != S_IDLE);

endmodule

`default_nettype wire

[rtl/stable_sorted_priority_queue.sv]
// top level of the stable sorted priority queue
//
//  channel   handshake          beat fields
//  command   start / busy       i_op, i_element, i_priority_req
//  result    o_strobe (1 cycle) o_removed_element, o_status, o_occupancy
//
//  rejected insert (full) or remove (empty): strobe in the cycle after the beat
//  remove: the REM state pops the head entry, then the strobe is registered
//  insert: the INS state walks stored entries of greater priority from the tail,
//  one per cycle through the ram ports, then the entry is put and the strobe registered
//  busy falls with the strobe of an accepted beat, so the next beat can be taken in that cycle
//  synchronous active-low reset empties the queue; results cannot be stalled
`default_nettype none

module stable_sorted_priority_queue import ssq_pkg::*; #(
    parameter int CAPACITY = CAPACITY_DEF
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  wire logic                     start,
    output logic                          busy,
    input  wire logic                     i_op,
    input  wire logic signed [ELEM_W-1:0] i_element,
    input  wire logic        [PRIO_W-1:0] i_priority_req,
    output logic                          o_strobe,
    output logic signed      [ELEM_W-1:0] o_removed_element,
    output logic             [1:0]        o_status,
    output logic             [OCC_W-1:0]  o_occupancy
);

    t_cmd  cmd;
    t_stat stat;

    ssq_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .i_op    (i_op),
        .i_stat  (stat),
        .o_cmd   (cmd),
        .o_busy  (busy)
    );

    ssq_dp #(
        .CAPACITY (CAPACITY)
    ) u_dp (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_element         (i_element),
        .i_priority_req    (i_priority_req),
        .i_cmd             (cmd),
        .o_stat            (stat),
        .o_strobe          (o_strobe),
        .o_removed_element (o_removed_element),
        .o_status          (o_status),
        .o_occupancy       (o_occupancy)
    );

    a_strobe_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> !busy)
        else $error("result strobe while busy");

    a_beat_progress: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> (busy || o_strobe))
        else $error("accepted beat neither busy nor answered");

    a_full_occ: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && o_status == ST_FULL) |-> (o_occupancy == OCC_W'(CAPACITY)))
        else $error("full reject with wrong occupancy");

    a_empty_res: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && o_status == ST_EMPTY) |-> (o_occupancy == '0 && o_removed_element == '0))
        else $error("empty reject with wrong result");

endmodule

`default_nettype wire
